// File: rtl/bpte_pkg.sv
// Shared types and constants for the Bezier point table evaluator.
// Depends on nothing; bpte_lerp, the top level and the testbench import it, bpte_ram does not.
package bpte_pkg;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } pt_t;

  localparam int PT_W = $bits(pt_t);
  localparam int T_W  = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_EVAL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CFG_START_LAT = 2'd0;
  localparam logic [1:0] CFG_START_LON = 2'd1;
  localparam logic [1:0] CFG_END_LAT   = 2'd2;
  localparam logic [1:0] CFG_END_LON   = 2'd3;

endpackage

// File: rtl/bpte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bpte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bpte_lerp.sv
// Two-coordinate fixed-point linear interpolation unit, one stage of multiply.
// Depends on bpte_pkg for the point type and the width of t.
module bpte_lerp import bpte_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  pt_t            a_i,
  input  pt_t            b_i,
  input  logic [T_W-1:0] t_i,
  output logic           vld_o,
  output pt_t            res_o
);

  logic signed [32:0]  dlat;
  logic signed [32:0]  dlon;
  logic signed [T_W:0] ts;
  logic signed [50:0]  plat_nxt;
  logic signed [50:0]  plon_nxt;
  logic signed [50:0]  plat_r;
  logic signed [50:0]  plon_r;
  logic signed [31:0]  alat_r;
  logic signed [31:0]  alon_r;
  logic                vld_r;
  logic signed [34:0]  slat;
  logic signed [34:0]  slon;

  always_comb begin
    dlat     = $signed({b_i.lat[31], b_i.lat}) - $signed({a_i.lat[31], a_i.lat});
    dlon     = $signed({b_i.lon[31], b_i.lon}) - $signed({a_i.lon[31], a_i.lon});
    ts       = $signed({1'b0, t_i});
    plat_nxt = dlat * ts;
    plon_nxt = dlon * ts;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    plat_r <= plat_nxt;
    plon_r <= plon_nxt;
    alat_r <= a_i.lat;
    alon_r <= a_i.lon;
  end

  // The product is truncated toward minus infinity by dropping its low 16 bits.
  assign slat      = $signed({{3{alat_r[31]}}, alat_r}) + $signed(plat_r[50:16]);
  assign slon      = $signed({{3{alon_r[31]}}, alon_r}) + $signed(plon_r[50:16]);
  assign res_o.lat = slat[31:0];
  assign res_o.lon = slon[31:0];
  assign vld_o     = vld_r;

endmodule

// File: rtl/bezier_point_table_evaluator_top.sv
// Top level of the Bezier point table evaluator: control table, work memory, sequencer.
// Depends on bpte_pkg, bpte_ram and bpte_lerp.
//
// Requests arrive on the in_ channel (valid/ready); each gives exactly one result on the
// out_ channel (valid/ready). The start and end points are written through the cfg_ port;
// the user must write them only while the block is idle, as the block does not enforce it.
// Requests are handled one at a time; in_ready is high only when no request is in
// progress, but a finished result may still be waiting in the output register while
// the next request is taken. Append, update, clear and unknown opcodes go straight to
// the result; remove first moves each entry above the removed slot down by one and
// then lowers the point count. Evaluate loads the start point, the stored points and
// the end point into the work memory and runs the De Casteljau levels down to one
// point. A new request is taken only after the previous result has been registered.
// Evaluation speed is set by the single read port of the work memory: each lerp of the
// De Casteljau pyramid reads one point per cycle, apart from a drain before the last
// level, and both coordinates share one multiplier pair whose product is registered
// before the add.
// If the receiver stalls, a result stays in the output register and one more request
// is processed up to its result, which then waits until the register is free.
// Reset (synchronous, active low) empties the table and clears the start and end points.
// Memory contents are not cleared; only entries below the point count are ever read.
module bezier_point_table_evaluator_top import bpte_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_point_lat,
  input  logic signed [31:0] in_point_lon,
  input  logic signed [31:0] in_param_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_curve_lat,
  output logic signed [31:0] out_curve_lon,
  output logic [1:0]         out_status,
  output logic [4:0]         out_point_count,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int WD = MAX_POINTS + 2;
  localparam int WW = $clog2(WD);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_LOAD, S_LOADE, S_LEVEL, S_DRAIN, S_FINAL, S_FIN
  } state_t;

  state_t              state_r;
  logic [NW-1:0]       count_r;
  pt_t                 start_r;
  pt_t                 end_r;
  logic [T_W-1:0]      t_r;
  logic [NW-1:0]       sh_r;
  logic [NW-1:0]       ld_r;
  logic                crd_v_r;
  logic [NW-1:0]       crd_a_r;
  logic [WW-1:0]       level_r;
  logic [WW-1:0]       idx_r;
  logic                wrd_v_r;
  logic                wrd_first_r;
  logic                wrd_last_r;
  logic [WW-1:0]       wrd_a_r;
  pt_t                 prev_r;
  logic [WW-1:0]       lw_a_r;
  logic                lw_last_r;
  logic signed [31:0]  res_lat_r;
  logic signed [31:0]  res_lon_r;
  logic [1:0]          res_status_r;
  logic                out_valid_r;
  logic signed [31:0]  out_lat_r;
  logic signed [31:0]  out_lon_r;
  logic [1:0]          out_status_r;
  logic [4:0]          out_count_r;

  logic                accept;
  logic [NW+3:0]       slot_ext;
  logic [NW+3:0]       cnt_ext;
  logic                slot_bad;
  logic                full;
  logic [NW+4:0]       cnt_out_ext;
  logic [NW-1:0]       crd_am1;

  logic                c_we;
  logic [CW-1:0]       c_wa;
  pt_t                 c_wd;
  logic [CW-1:0]       c_ra;
  pt_t                 c_rdata;

  logic                w_we;
  logic [WW-1:0]       w_wa;
  pt_t                 w_wd;
  pt_t                 w_rdata;

  logic                lerp_in_vld;
  logic                lerp_vld;
  pt_t                 lerp_res;
  pt_t                 in_pt;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign slot_ext    = {{NW{1'b0}}, in_slot};
  assign cnt_ext     = {4'd0, count_r};
  assign slot_bad    = (slot_ext >= cnt_ext);
  assign full        = (count_r >= NW'(MAX_POINTS));
  assign cnt_out_ext = {5'd0, count_r};
  assign crd_am1     = crd_a_r - NW'(1);
  assign in_pt.lat   = in_point_lat;
  assign in_pt.lon   = in_point_lon;

  always_comb begin
    c_we = 1'b0;
    c_wa = count_r[CW-1:0];
    c_wd = in_pt;
    if (accept && in_opcode == OP_APPEND && !full) begin
      c_we = 1'b1;
    end else if (accept && in_opcode == OP_UPDATE && !slot_bad) begin
      c_we = 1'b1;
      c_wa = slot_ext[CW-1:0];
    end else if (state_r == S_SHIFT && crd_v_r) begin
      c_we = 1'b1;
      c_wa = crd_am1[CW-1:0];
      c_wd = c_rdata;
    end
    c_ra = (state_r == S_SHIFT) ? sh_r[CW-1:0] : ld_r[CW-1:0];
  end

  always_comb begin
    w_we = 1'b0;
    w_wa = lw_a_r;
    w_wd = lerp_res;
    case (state_r)
      S_LOAD: begin
        if (crd_v_r) begin
          w_we = 1'b1;
          w_wa = WW'(crd_a_r) + WW'(1);
          w_wd = c_rdata;
        end else if (ld_r == '0) begin
          w_we = 1'b1;
          w_wa = '0;
          w_wd = start_r;
        end
      end
      S_LOADE: begin
        w_we = 1'b1;
        w_wa = WW'(count_r) + WW'(1);
        w_wd = end_r;
      end
      default: begin
        w_we = lerp_vld;
      end
    endcase
  end

  bpte_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS),
    .AW    (CW)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_wa),
    .wdata (c_wd),
    .raddr (c_ra),
    .rdata (c_rdata)
  );

  bpte_ram #(
    .WIDTH (PT_W),
    .DEPTH (WD),
    .AW    (WW)
  ) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_wa),
    .wdata (w_wd),
    .raddr (idx_r),
    .rdata (w_rdata)
  );

  assign lerp_in_vld = wrd_v_r && !wrd_first_r;

  bpte_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (lerp_in_vld),
    .a_i   (prev_r),
    .b_i   (w_rdata),
    .t_i   (t_r),
    .vld_o (lerp_vld),
    .res_o (lerp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_LAT: start_r.lat <= cfg_data;
        CFG_START_LON: start_r.lon <= cfg_data;
        CFG_END_LAT:   end_r.lat   <= cfg_data;
        CFG_END_LON:   end_r.lon   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      crd_v_r     <= 1'b0;
      wrd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crd_v_r <= 1'b0;
      wrd_v_r <= 1'b0;
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wrd_v_r) begin
        prev_r <= w_rdata;
      end
      lw_a_r    <= wrd_a_r - WW'(1);
      lw_last_r <= wrd_last_r;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_lat_r    <= '0;
            res_lon_r    <= '0;
            res_status_r <= ST_OK;
            state_r      <= S_FIN;
            if (in_param_t[31]) begin
              t_r <= '0;
            end else if (in_param_t > 32'sd65536) begin
              t_r <= T_ONE;
            end else begin
              t_r <= in_param_t[T_W-1:0];
            end
            case (in_opcode)
              OP_APPEND: begin
                if (full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  count_r <= count_r + NW'(1);
                end
              end
              OP_REMOVE: begin
                if (slot_bad) begin
                  res_status_r <= ST_RANGE;
                end else begin
                  sh_r    <= slot_ext[NW-1:0] + NW'(1);
                  state_r <= S_SHIFT;
                end
              end
              OP_UPDATE: begin
                if (slot_bad) begin
                  res_status_r <= ST_RANGE;
                end
              end
              OP_CLEAR: begin
                count_r <= '0;
              end
              OP_EVAL: begin
                ld_r    <= '0;
                state_r <= S_LOAD;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (sh_r < count_r) begin
            crd_v_r <= 1'b1;
            crd_a_r <= sh_r;
            sh_r    <= sh_r + NW'(1);
          end else if (!crd_v_r) begin
            count_r <= count_r - NW'(1);
            state_r <= S_FIN;
          end
        end
        S_LOAD: begin
          if (ld_r < count_r) begin
            crd_v_r <= 1'b1;
            crd_a_r <= ld_r;
            ld_r    <= ld_r + NW'(1);
          end else begin
            state_r <= S_LOADE;
          end
        end
        S_LOADE: begin
          level_r <= WW'(count_r) + WW'(1);
          idx_r   <= '0;
          state_r <= S_LEVEL;
        end
        S_LEVEL: begin
          wrd_v_r     <= 1'b1;
          wrd_a_r     <= idx_r;
          wrd_first_r <= (idx_r == '0);
          wrd_last_r  <= (level_r == WW'(1)) && (idx_r == WW'(1));
          if (idx_r == level_r) begin
            idx_r <= '0;
            if (level_r == WW'(1)) begin
              state_r <= S_FINAL;
            end else begin
              level_r <= level_r - WW'(1);
              // A short level would read a point before its new value is written.
              if (level_r == WW'(2)) begin
                state_r <= S_DRAIN;
              end
            end
          end else begin
            idx_r <= idx_r + WW'(1);
          end
        end
        S_DRAIN: begin
          if (!wrd_v_r && !lerp_vld) begin
            state_r <= S_LEVEL;
          end
        end
        S_FINAL: begin
          if (lerp_vld && lw_last_r) begin
            res_lat_r <= lerp_res.lat;
            res_lon_r <= lerp_res.lon;
            state_r   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_lat_r    <= res_lat_r;
            out_lon_r    <= res_lon_r;
            out_status_r <= res_status_r;
            out_count_r  <= cnt_out_ext[4:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_lat   = out_lat_r;
  assign out_curve_lon   = out_lon_r;
  assign out_status      = out_status_r;
  assign out_point_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_POINTS))
    else $error("point count exceeds table depth");

  a_work_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEVEL && lerp_vld) |-> (idx_r != lw_a_r))
    else $error("work memory read collides with a pending write");

  a_lerp_phase: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_vld |-> (state_r == S_LEVEL || state_r == S_DRAIN || state_r == S_FINAL))
    else $error("lerp result outside the evaluation phase");

  a_ctrl_write: assert property (@(posedge clk) disable iff (!rst_n)
    c_we |-> (accept || state_r == S_SHIFT))
    else $error("control table written outside an update");

  a_fin_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_ready) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not moved to the output register");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for bezier_point_table_evaluator_top: table edits and curve evaluation.
// A directed table runs first, then random requests are checked against an internal predictor.
// Depends on bpte_pkg and the RTL of the block; it reads no file.
`timescale 1ns / 100ps

module testbench;
  import bpte_pkg::*;

  localparam int MAX_PTS = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_ITEMS = 205;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_FULL = 32'sd65536;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] tval;
  } table_req_t;

  typedef struct packed {
    logic signed [31:0] curve_lat;
    logic signed [31:0] curve_lon;
    logic [1:0]         status;
    logic [4:0]         count;
  } curve_res_t;

  typedef struct packed {
    table_req_t rq;
    bit         typed;
    curve_res_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_opcode = '0;
  logic [3:0]         in_slot = '0;
  logic signed [31:0] in_point_lat = '0;
  logic signed [31:0] in_point_lon = '0;
  logic signed [31:0] in_param_t = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_curve_lat;
  logic signed [31:0] out_curve_lon;
  logic [1:0]         out_status;
  logic [4:0]         out_point_count;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  pt_t        ctl_pts [MAX_PTS];
  int         n_pts = 0;
  pt_t        start_pt = '0;
  pt_t        end_pt = '0;
  curve_res_t due_results [$];
  curve_res_t want_res;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  dir_row_t   dir_rows [25];

  bezier_point_table_evaluator_top #(.MAX_POINTS(MAX_PTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode), .in_slot(in_slot),
    .in_point_lat(in_point_lat), .in_point_lon(in_point_lon), .in_param_t(in_param_t),
    .out_valid(out_valid), .out_ready(out_ready), .out_curve_lat(out_curve_lat),
    .out_curve_lon(out_curve_lon), .out_status(out_status), .out_point_count(out_point_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint lerp_coord(longint a, longint b, longint tc);
    return a + (((b - a) * tc) >>> 16);
  endfunction

  function automatic curve_res_t apply_request(table_req_t r);
    curve_res_t res;
    longint     wl [MAX_PTS+2];
    longint     wn [MAX_PTS+2];
    longint     tc;
    int         i;
    int         lvl;
    int         n;
    res = '0;
    case (r.op)
      OP_APPEND: begin
        if (n_pts >= MAX_PTS) begin
          res.status = ST_FULL;
        end else begin
          ctl_pts[n_pts] = '{r.lat, r.lon};
          n_pts++;
        end
      end
      OP_REMOVE: begin
        if (int'(r.slot) >= n_pts) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(r.slot); i + 1 < n_pts; i++) ctl_pts[i] = ctl_pts[i+1];
          n_pts--;
        end
      end
      OP_UPDATE: begin
        if (int'(r.slot) >= n_pts) begin
          res.status = ST_RANGE;
        end else begin
          ctl_pts[r.slot] = '{r.lat, r.lon};
        end
      end
      OP_CLEAR: begin
        n_pts = 0;
      end
      OP_EVAL: begin
        tc = r.tval;
        if (tc < 0) tc = 0;
        if (tc > 65536) tc = 65536;
        wl[0] = start_pt.lat;
        wn[0] = start_pt.lon;
        for (i = 0; i < n_pts; i++) begin
          wl[i+1] = ctl_pts[i].lat;
          wn[i+1] = ctl_pts[i].lon;
        end
        n = n_pts + 2;
        wl[n-1] = end_pt.lat;
        wn[n-1] = end_pt.lon;
        for (lvl = n - 1; lvl >= 1; lvl--) begin
          for (i = 0; i < lvl; i++) begin
            wl[i] = lerp_coord(wl[i], wl[i+1], tc);
            wn[i] = lerp_coord(wn[i], wn[i+1], tc);
          end
        end
        res.curve_lat = wl[0][31:0];
        res.curve_lon = wn[0][31:0];
      end
      default: begin
      end
    endcase
    res.count = 5'(n_pts);
    return res;
  endfunction

  function automatic dir_row_t step_row(logic [2:0] op, logic [3:0] slot,
                                        logic signed [31:0] lat, logic signed [31:0] lon,
                                        logic signed [31:0] tval, bit typed,
                                        logic signed [31:0] wlat, logic signed [31:0] wlon,
                                        logic [1:0] wst, logic [4:0] wcnt);
    dir_row_t d;
    d.rq = '{op, slot, lat, lon, tval};
    d.typed = typed;
    d.want = '{wlat, wlon, wst, wcnt};
    return d;
  endfunction

  function automatic int idle_len(bit calm);
    int unsigned w;
    if (calm) return 0;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic table_req_t random_request(bit grow);
    table_req_t  r;
    int unsigned w;
    r.lat = random_coord();
    r.lon = random_coord();
    w = $urandom_range(0, 99);
    if (grow) begin
      if (w < 55) r.op = OP_APPEND;
      else if (w < 62) r.op = OP_REMOVE;
      else if (w < 70) r.op = OP_UPDATE;
      else r.op = OP_EVAL;
    end else begin
      if (w < 25) r.op = OP_APPEND;
      else if (w < 40) r.op = OP_REMOVE;
      else if (w < 55) r.op = OP_UPDATE;
      else if (w < 60) r.op = OP_CLEAR;
      else if (w < 97) r.op = OP_EVAL;
      else r.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    end
    if (n_pts > 0 && $urandom_range(0, 3) != 0) r.slot = 4'($urandom_range(0, n_pts - 1));
    else r.slot = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: r.tval = 0;
      1: r.tval = T_FULL;
      2: r.tval = $urandom;
      default: r.tval = $urandom_range(0, 65536);
    endcase
    return r;
  endfunction

  task automatic load_points(pt_t s, pt_t e);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_LAT;
    cfg_data <= s.lat;
    @(posedge clk);
    cfg_index <= CFG_START_LON;
    cfg_data <= s.lon;
    @(posedge clk);
    cfg_index <= CFG_END_LAT;
    cfg_data <= e.lat;
    @(posedge clk);
    cfg_index <= CFG_END_LON;
    cfg_data <= e.lon;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_pt = s;
    end_pt = e;
  endtask

  task automatic issue(table_req_t r, bit typed, curve_res_t want);
    int         gap;
    curve_res_t got;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_slot <= r.slot;
    in_point_lat <= r.lat;
    in_point_lon <= r.lon;
    in_param_t <= r.tval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = apply_request(r);
    due_results.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want_res = due_results.pop_front();
        if (out_curve_lat !== want_res.curve_lat) begin
          $error("curve_lat: expected %0d, got %0d", want_res.curve_lat, out_curve_lat);
          mismatch_count++;
        end
        if (out_curve_lon !== want_res.curve_lon) begin
          $error("curve_lon: expected %0d, got %0d", want_res.curve_lon, out_curve_lon);
          mismatch_count++;
        end
        if (out_status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_status);
          mismatch_count++;
        end
        if (out_point_count !== want_res.count) begin
          $error("point_count: expected %0d, got %0d", want_res.count, out_point_count);
          mismatch_count++;
        end
      end
    end
    if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len(rx_calm);
    end
  end

  initial begin
    int         k;
    int         phase;
    int         sent;
    int         grow_left;
    bit         grow;
    table_req_t r;
    pt_t        s;
    pt_t        e;

    dir_rows = '{
      step_row(OP_EVAL,   4'd0,  0, 0, 0,      1, Q_MIN, Q_MAX, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, T_FULL, 1, Q_MAX, Q_MIN, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, -1,     1, Q_MIN, Q_MAX, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, Q_MAX,  1, Q_MAX, Q_MIN, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, Q_MIN,  1, Q_MIN, Q_MAX, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, 32768,  0, 0, 0, ST_OK, 5'd0),
      step_row(OP_REMOVE, 4'd0,  0, 0, 0,      1, 0, 0, ST_RANGE, 5'd0),
      step_row(OP_UPDATE, 4'd15, Q_MAX, Q_MIN, 0, 1, 0, 0, ST_RANGE, 5'd0),
      step_row(OP_CLEAR,  4'd0,  0, 0, 0,      1, 0, 0, ST_OK, 5'd0),
      step_row(OP_RSVD5,  4'd15, Q_MAX, Q_MIN, T_FULL, 1, 0, 0, ST_OK, 5'd0),
      step_row(OP_RSVD6,  4'd7,  Q_MIN, Q_MAX, 32768,  1, 0, 0, ST_OK, 5'd0),
      step_row(OP_RSVD7,  4'd0,  -1, -1, -1,   1, 0, 0, ST_OK, 5'd0),
      step_row(OP_APPEND, 4'd0,  Q_MIN, Q_MAX, 0, 1, 0, 0, ST_OK, 5'd1),
      step_row(OP_APPEND, 4'd0,  Q_MAX, Q_MIN, 0, 1, 0, 0, ST_OK, 5'd2),
      step_row(OP_APPEND, 4'd0,  0, -1, 0,     1, 0, 0, ST_OK, 5'd3),
      step_row(OP_EVAL,   4'd0,  0, 0, 1,      0, 0, 0, ST_OK, 5'd0),
      step_row(OP_UPDATE, 4'd1,  12345, -6789, 0, 1, 0, 0, ST_OK, 5'd3),
      step_row(OP_UPDATE, 4'd3,  1, 1, 0,      1, 0, 0, ST_RANGE, 5'd3),
      step_row(OP_REMOVE, 4'd15, 0, 0, 0,      1, 0, 0, ST_RANGE, 5'd3),
      step_row(OP_EVAL,   4'd0,  0, 0, 65535,  0, 0, 0, ST_OK, 5'd0),
      step_row(OP_REMOVE, 4'd0,  0, 0, 0,      1, 0, 0, ST_OK, 5'd2),
      step_row(OP_EVAL,   4'd0,  0, 0, T_FULL, 1, Q_MAX, Q_MIN, ST_OK, 5'd2),
      step_row(OP_EVAL,   4'd0,  0, 0, 0,      1, Q_MIN, Q_MAX, ST_OK, 5'd2),
      step_row(OP_CLEAR,  4'd0,  0, 0, 0,      1, 0, 0, ST_OK, 5'd0),
      step_row(OP_EVAL,   4'd0,  0, 0, 40000,  0, 0, 0, ST_OK, 5'd0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_points('{Q_MIN, Q_MAX}, '{Q_MAX, Q_MIN});
    for (k = 0; k < 25; k++) issue(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);

    grow = 1'b0;
    grow_left = 0;
    for (phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          s = '0;
          e = '0;
        end
        3: begin
          s = '{Q_MAX, Q_MAX};
          e = '{Q_MIN, Q_MIN};
        end
        default: begin
          s = '{random_coord(), random_coord()};
          e = '{random_coord(), random_coord()};
        end
      endcase
      load_points(s, e);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (grow_left == 0) begin
          grow = ($urandom_range(0, 2) == 0);
          grow_left = $urandom_range(20, 60);
        end
        grow_left--;
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        r = random_request(grow);
        if (r.op <= OP_EVAL) sent++;
        issue(r, 1'b0, '0);
      end
      in_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
